[rtl/s2u8_pkg.sv]
package s2u8_pkg;

    // Width of one output code and the number of binary search steps.
    localparam int CODE_W = 8;

    // Entries in the decision threshold table, entry zero included.
    localparam int TAB_N = 2 ** CODE_W;

    // Widest fixed-point value that the converter can produce.
    localparam int FIX_MAX_W = 33;

    // Clock edges from acceptance to the edge that ends the result cycle.
    localparam int PIPE_LAT = CODE_W + 1;

    typedef logic [CODE_W-1:0] code_t;

    // Clamps a single-precision pattern to [0,1] and truncates it to an unsigned
    // fixed-point value with frac fraction bits. NaN and negative inputs give zero.
    function automatic logic [FIX_MAX_W-1:0] to_fixed(input logic [31:0] b, input int frac);
        logic [7:0]           ex;
        logic [FIX_MAX_W-1:0] m;
        logic [FIX_MAX_W-1:0] res;
        int                   e;
        int                   s;
        ex  = b[30:23];
        m   = {10'd0, b[22:0]};
        e   = int'(ex);
        res = '0;
        if (ex == 8'hFF && b[22:0] != 23'd0) begin
            res = '0;
        end
        else if (b[31]) begin
            res = '0;
        end
        else if (ex >= 8'd127) begin
            res = FIX_MAX_W'(1) << frac;
        end
        else begin
            if (ex == 8'd0) begin
                e = 1;
            end
            else begin
                m[23] = 1'b1;
            end
            s = e - 150 + frac;
            if (s >= 0) begin
                res = m << s;
            end
            else begin
                res = m >> (-s);
            end
        end
        return res;
    endfunction

    // Exact decision threshold for code k at frac fraction bits: the ceiling of
    // the linear value at which the rounded code reaches k. Used at elaboration.
    function automatic logic [FIX_MAX_W-1:0] thr_at(input int k, input int frac);
        logic [383:0] den12;
        logic [383:0] pw;
        logic [383:0] rhs;
        logic [383:0] xb;
        logic [383:0] x5;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [63:0]  num;
        logic [63:0]  t32;
        int           i;
        int           sh;
        sh = 32 - frac;
        if (k <= 10) begin
            num = 64'((2 * k - 1) * 5) << 32;
            t32 = (num + 64'd32945) / 64'd32946;
        end
        else begin
            den12 = 384'd1;
            for (i = 0; i < 12; i++) begin
                den12 = den12 * 384'd10761;
            end
            pw = 384'd1;
            for (i = 0; i < 12; i++) begin
                pw = pw * 384'(40 * k + 541);
            end
            rhs = pw << 160;
            lo  = 64'd0;
            hi  = 64'd1 << 32;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                xb  = 384'(mid);
                x5  = 384'd1;
                for (i = 0; i < 5; i++) begin
                    x5 = x5 * xb;
                end
                if (x5 * den12 >= rhs) begin
                    hi = mid;
                end
                else begin
                    lo = mid + 64'd1;
                end
            end
            t32 = lo;
        end
        t32 = (t32 + ((64'd1 << sh) - 64'd1)) >> sh;
        return t32[FIX_MAX_W-1:0];
    endfunction

endpackage

[rtl/s2u8_lane.sv]
module s2u8_lane #(
    parameter int FRAC = 24
) (
    input  logic                 clk,
    input  logic [31:0]          bits,
    output s2u8_pkg::code_t      code
);

    localparam int XW = FRAC + 1;
    localparam int NSTEP = s2u8_pkg::CODE_W;

    typedef logic [s2u8_pkg::TAB_N-1:0][XW-1:0] thr_tab_t;

    function automatic thr_tab_t build_thr();
        thr_tab_t                         tab;
        logic [s2u8_pkg::FIX_MAX_W-1:0]   t;
        int                               k;
        tab[0] = '0;
        for (k = 1; k < s2u8_pkg::TAB_N; k++) begin
            t      = s2u8_pkg::thr_at(k, FRAC);
            tab[k] = t[XW-1:0];
        end
        return tab;
    endfunction

    localparam thr_tab_t THR = build_thr();

    logic [s2u8_pkg::FIX_MAX_W-1:0] fix_full;
    logic [XW-1:0]                  x_reg    [NSTEP];
    s2u8_pkg::code_t                code_reg [1:NSTEP];

    assign fix_full = s2u8_pkg::to_fixed(bits, FRAC);

    always_ff @(posedge clk)
    begin
        x_reg[0] <= fix_full[XW-1:0];
    end

    // One step of the binary search per stage, most significant code bit first.
    // The thresholds rise with the code, so the largest code whose threshold the
    // value reaches is the count of thresholds above entry zero that it reaches.
    for (genvar s = 0; s < NSTEP; s++)
    begin : g_step
        s2u8_pkg::code_t prefix;
        s2u8_pkg::code_t cand;

        if (s == 0)
        begin : g_first
            assign prefix = '0;
        end
        else
        begin : g_rest
            assign prefix = code_reg[s];
        end

        assign cand = prefix | (s2u8_pkg::code_t'(1) << (NSTEP - 1 - s));

        always_ff @(posedge clk)
        begin
            code_reg[s+1] <= (x_reg[s] >= THR[cand]) ? cand : prefix;
        end

        if (s < NSTEP - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                x_reg[s+1] <= x_reg[s];
            end
        end
    end

    assign code = code_reg[NSTEP];

endmodule

[rtl/srgb_encode_to_unorm8.sv]
// Result: a pixel accepted at one clock edge has its codes on the outputs, with done high,
// for a single cycle, once it has passed the conversion register and the search stages.
// Throughput: one pixel per clock; busy is held low, so start may be high every cycle.
// The depth is set by the float conversion stage plus one threshold search step per code bit.
// Reset: rst_n clears the valid chain asynchronously; no result is flagged after reset
// until a new pixel has passed through. The receiver cannot stall the block.
module srgb_encode_to_unorm8 #(
    parameter int FIXED_FRACTION_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] red_in,
    input  logic [31:0] green_in,
    input  logic [31:0] blue_in,
    input  logic [31:0] alpha_in,
    output logic        done,
    output logic [7:0]  red_code,
    output logic [7:0]  green_code,
    output logic [7:0]  blue_code,
    output logic [7:0]  alpha_code
);

    localparam int XW   = FIXED_FRACTION_BITS + 1;
    localparam int CW   = s2u8_pkg::CODE_W;
    localparam int AW   = XW + CW;
    localparam int LAT  = s2u8_pkg::PIPE_LAT;

    // Rounding constant for the alpha quantizer: one half in fixed point.
    localparam logic [AW-1:0] HALF = AW'(1) << (FIXED_FRACTION_BITS - 1);

    logic                           accept;
    logic [LAT-1:0]                 valid_reg;
    logic [s2u8_pkg::FIX_MAX_W-1:0] alpha_fix;
    logic [XW-1:0]                  alpha_x_reg;
    logic [AW-1:0]                  alpha_wide;
    s2u8_pkg::code_t                alpha_reg [1:CW];

    // Nothing downstream can push back and every stage advances each cycle,
    // so the block is always ready for the next transaction.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // The valid flag travels alongside the data; the data registers themselves
    // run freely and carry no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAT-2:0], accept};
        end
    end

    assign done = valid_reg[LAT-1];

    // The three colour channels each get a conversion stage and the threshold search.
    s2u8_lane #(
        .FRAC (FIXED_FRACTION_BITS)
    ) u_red (
        .clk  (clk),
        .bits (red_in),
        .code (red_code)
    );

    s2u8_lane #(
        .FRAC (FIXED_FRACTION_BITS)
    ) u_green (
        .clk  (clk),
        .bits (green_in),
        .code (green_code)
    );

    s2u8_lane #(
        .FRAC (FIXED_FRACTION_BITS)
    ) u_blue (
        .clk  (clk),
        .bits (blue_in),
        .code (blue_code)
    );

    // Alpha is clamped in the same way but quantized linearly: 255 times the
    // fixed-point value, written as a shift and a subtract, plus one half, then
    // the integer part. It is then delayed to line up with the colour codes.
    assign alpha_fix = s2u8_pkg::to_fixed(alpha_in, FIXED_FRACTION_BITS);

    always_ff @(posedge clk)
    begin
        alpha_x_reg <= alpha_fix[XW-1:0];
    end

    assign alpha_wide = {alpha_x_reg, CW'(0)} - {CW'(0), alpha_x_reg} + HALF;

    always_ff @(posedge clk)
    begin
        alpha_reg[1] <= alpha_wide[AW-2 -: CW];
        for (int s = 2; s <= CW; s++)
        begin
            alpha_reg[s] <= alpha_reg[s-1];
        end
    end

    assign alpha_code = alpha_reg[CW];

endmodule

[rtl/s2u8_chk.sv]
module s2u8_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] red_in,
    input logic [31:0] alpha_in,
    input logic        done,
    input logic [7:0]  red_code,
    input logic [7:0]  alpha_code
);

    localparam int LAT = s2u8_pkg::PIPE_LAT;

    // The block never refuses a transaction.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy == 1'b0)
        else $error("busy raised");

    // Every accepted transaction produces exactly one result at the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after accepted transaction");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without an accepted transaction");

    // A negative red channel saturates to code zero.
    a_red_negative: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && red_in[31]) |-> ##LAT (red_code == 8'd0))
        else $error("negative red did not give code zero");

    // Alpha of one or more, infinity and NaN excluded, saturates to full scale.
    a_alpha_full: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !alpha_in[31] && alpha_in[30:23] >= 8'd127
            && alpha_in[30:23] != 8'hFF) |-> ##LAT (alpha_code == 8'd255))
        else $error("alpha of one did not give full scale");

endmodule

bind srgb_encode_to_unorm8 s2u8_chk u_s2u8_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .red_in     (red_in),
    .alpha_in   (alpha_in),
    .done       (done),
    .red_code   (red_code),
    .alpha_code (alpha_code)
);
